### rtl/pmct_pkg.sv
// Package for the PS/2 mouse packet cursor tracker.
// Holds the shared types, register indexes and framing constants.
// No dependencies.
`default_nettype none

package pmct_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 12;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned DxW      = 9;
  localparam int unsigned DyW      = 10;
  localparam int unsigned BtnW     = 3;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] HdrMask   = 8'hc8;
  localparam logic [ByteW-1:0] HdrWant   = 8'h08;
  localparam int unsigned      SignXBit  = 4;
  localparam int unsigned      SignYBit  = 5;
  localparam logic [PosW-1:0]  CursorStart = 12'd10;
  localparam logic [SizeW-1:0] WidthReset  = 13'd640;
  localparam logic [SizeW-1:0] HeightReset = 13'd480;
  localparam logic [SizeW-1:0] SizeMax     = 13'd4096;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_HEADER = 2'd1,
    PH_X      = 2'd2,
    PH_Y      = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] y_byte;
    logic [ByteW-1:0] x_byte;
    logic [ByteW-1:0] header;
  } pkt_t;

  typedef struct packed {
    logic                valid;
    logic [CfgAddrW-1:0] addr;
    logic [SizeW-1:0]    data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### rtl/ps2_mouse_packet_cursor_tracker_top.sv
// PS/2 mouse packet decoder with cursor tracking: top level.
// Path: a packet whose third byte is taken is written into the queue, then loaded
// into the single output register when it is free, and shows on m_axis.
// Throughput: one byte per cycle while the queue has room; set by the framer, the
// two-entry queue and output register, which pops a packet per cycle when free.
// Reset (rst_ni low, asynchronous): the next byte is dropped as acknowledge,
// cursor at (10,10), buttons released, screen 640 x 480, queue empty.
`default_nettype none

module ps2_mouse_packet_cursor_tracker_top
  import pmct_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [32:24] delta_x, [42:33] delta_y,
  // [45:43] buttons_held, [48:46] buttons_pressed, [51:49] buttons_released,
  // [52] moved, [55:53] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [SizeW-1:0]    cfg_data_i
);

  logic    q_full, q_empty, push_valid, pop;
  pkt_t    push_pkt, pop_pkt;
  cfg_wr_t cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg         = '{valid: cfg_valid_i, addr: cfg_addr_i, data: cfg_data_i};

  pmct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .push_ready_i (!q_full),
    .byte_ready_o (s_axis_tready),
    .push_valid_o (push_valid),
    .push_pkt_o   (push_pkt)
  );

  pmct_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_pkt_i (push_pkt),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .pop_pkt_o  (pop_pkt)
  );

  pmct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pkt_valid_i (!q_empty),
    .pkt_i       (pop_pkt),
    .pkt_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### rtl/pmct_front.sv
// Byte framer: drops the acknowledge byte, checks headers, gathers packets.
// Depends on pmct_pkg.
`default_nettype none

module pmct_front
  import pmct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_valid_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             push_ready_i,
  output logic                  byte_ready_o,
  output logic                  push_valid_o,
  output pkt_t                  push_pkt_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] header_q, x_q;
  logic             take;

  assign byte_ready_o = push_ready_i;
  assign take         = byte_valid_i && push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && phase_q == PH_HEADER) begin
      header_q <= byte_i;
    end
    if (take && phase_q == PH_X) begin
      x_q <= byte_i;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    push_valid_o = 1'b0;
    push_pkt_o   = '{y_byte: byte_i, x_byte: x_q, header: header_q};
    if (take) begin
      case (phase_q)
        PH_SKIP: phase_d = PH_HEADER;
        PH_HEADER: begin
          if ((byte_i & HdrMask) == HdrWant) begin
            phase_d = PH_X;
          end
        end
        PH_X: phase_d = PH_Y;
        PH_Y: begin
          phase_d      = PH_HEADER;
          push_valid_o = 1'b1;
        end
        default: phase_d = PH_SKIP;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pmct_queue.sv
// Two-entry packet queue between the framer and the cursor update.
// Depends on pmct_pkg.
`default_nettype none

module pmct_queue
  import pmct_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire pkt_t push_pkt_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output pkt_t      pop_pkt_o
);

  pkt_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_pkt_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pmct_back.sv
// Packet executor: forms deltas, moves and clamps the cursor, tracks buttons.
// Holds the screen size registers and the output register. Depends on pmct_pkg.
`default_nettype none

module pmct_back
  import pmct_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_wr_t             cfg_i,
  input  wire logic                pkt_valid_i,
  input  wire pkt_t                pkt_i,
  output logic                     pkt_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o
);

  logic [SizeW-1:0]  width_q, height_q;
  logic [PosW-1:0]   col_q, col_d, row_q, row_d;
  logic [BtnW-1:0]   held_q, nb, pressed, released;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic signed [DxW-1:0] dx;
  logic signed [DyW-1:0] dy, dx_ext;
  logic              moved;

  function automatic logic [PosW-1:0] move_clamp(logic [PosW-1:0] pos,
                                                 logic signed [DyW-1:0] d,
                                                 logic [SizeW-1:0] size);
    logic [SizeW-1:0]      lim;
    logic signed [PosW+1:0] p;
    begin
      if (size == '0) begin
        lim = SizeW'(1);
      end else if (size > SizeMax) begin
        lim = SizeMax;
      end else begin
        lim = size;
      end
      p = $signed({2'b00, pos}) + $signed({{4{d[DyW-1]}}, d});
      if (p[PosW+1]) begin
        move_clamp = '0;
      end else if (p[SizeW-1:0] >= lim) begin
        move_clamp = PosW'(lim - SizeW'(1));
      end else begin
        move_clamp = p[PosW-1:0];
      end
    end
  endfunction

  assign pkt_pop_o   = pkt_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    dx       = $signed({pkt_i.header[SignXBit], pkt_i.x_byte});
    dx_ext   = $signed({dx[DxW-1], dx});
    dy       = $signed(DyW'(0)) - $signed({pkt_i.header[SignYBit],
                                          pkt_i.header[SignYBit], pkt_i.y_byte});
    nb       = pkt_i.header[BtnW-1:0];
    pressed  = nb & ~held_q;
    released = held_q & ~nb;
    moved    = (dx != '0) || (dy != '0);
    col_d    = col_q;
    row_d    = row_q;
    if (moved) begin
      col_d = move_clamp(col_q, dx_ext, width_q);
      row_d = move_clamp(row_q, dy, height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      col_q       <= CursorStart;
      row_q       <= CursorStart;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.addr)
          REG_SCREEN_WIDTH:  width_q  <= cfg_i.data;
          REG_SCREEN_HEIGHT: height_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (pkt_pop_o) begin
        col_q       <= col_d;
        row_q       <= row_d;
        held_q      <= nb;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_pop_o) begin
      out_data_q <= {3'b000, moved, released, pressed, nb, dy, dx, row_d, col_d};
    end
  end

endmodule

`default_nettype wire

### rtl/pmct_checker.sv
// Port-level checker for the cursor tracker, bound to the top level.
// Depends on pmct_pkg.
`default_nettype none

module pmct_checker
  import pmct_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_i,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_i
);

  logic [DxW-1:0]  dx;
  logic [DyW-1:0]  dy;
  logic [BtnW-1:0] held, pressed, released;
  logic            moved;

  assign dx       = m_axis_tdata_i[32:24];
  assign dy       = m_axis_tdata_i[42:33];
  assign held     = m_axis_tdata_i[45:43];
  assign pressed  = m_axis_tdata_i[48:46];
  assign released = m_axis_tdata_i[51:49];
  assign moved    = m_axis_tdata_i[52];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> moved == ((dx != '0) || (dy != '0)))
    else $error("moved flag disagrees with deltas");

  a_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (pressed & ~held) == '0)
    else $error("pressed button not held");

  a_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (released & held) == '0)
    else $error("released button still held");

endmodule

bind ps2_mouse_packet_cursor_tracker_top pmct_checker u_pmct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);

`default_nettype wire
